@@ rtl/spq_pkg.sv @@
// Shared types, constants and the ordering function of the stable priority queue.
package spq_pkg;

  localparam int unsigned CAPACITY_DEF = 256;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] sev;
    logic [15:0] id;
    logic [31:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    RD_ROOT,
    RD_PARENT,
    RD_LAST,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_e;

  typedef enum logic [1:0] {
    WS_ITEM,
    WS_RDATA,
    WS_BEST
  } wr_src_e;

  typedef enum logic [2:0] {
    PS_HOLD,
    PS_OCC,
    PS_ZERO,
    PS_PARENT,
    PS_LEFT,
    PS_RIGHT,
    PS_BEST
  } pos_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_TOP,
    S_DN_LAST,
    S_DN_CHK,
    S_DN_L,
    S_DN_R
  } state_e;

  typedef struct packed {
    logic     load_ins;
    logic     load_last;
    logic     cap_top;
    logic     take_left;
    logic     occ_dec;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     wr_en;
    wr_src_e  wr_src;
    pos_sel_e pos_sel;
    logic     finish;
    status_e  status;
  } cmd_t;

  typedef struct packed {
    logic occ_zero;
    logic occ_full;
    logic pos_zero;
    logic l_in;
    logic r_in;
    logic up_win;
    logic l_win;
    logic r_win;
    logic best_child;
  } stat_t;

  // True when entry x must be served before entry y.
  function automatic logic goes_first(entry_t x, entry_t y);
    logic res;
    if (x.sev != y.sev) begin
      res = x.sev > y.sev;
    end else begin
      res = x.stamp < y.stamp;
    end
    return res;
  endfunction

endpackage

@@ rtl/spq_ctrl.sv @@
// Controller state machine that sequences heap inserts and serves.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  logic  mode_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (!mode_i) begin
            if (stat_i.occ_full) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.load_ins = 1'b1;
              cmd_o.pos_sel  = PS_OCC;
              state_d        = S_UP_CHK;
            end
          end else begin
            if (stat_i.occ_zero) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_EMPTY;
            end else begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_sel  = RD_ROOT;
              cmd_o.occ_dec = 1'b1;
              state_d       = S_DN_TOP;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (stat_i.pos_zero) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_src = WS_ITEM;
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_INSERTED;
          state_d      = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PARENT;
          state_d      = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.up_win) begin
          cmd_o.wr_src  = WS_RDATA;
          cmd_o.pos_sel = PS_PARENT;
          state_d       = S_UP_CHK;
        end else begin
          cmd_o.wr_src = WS_ITEM;
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_INSERTED;
          state_d      = S_IDLE;
        end
      end
      S_DN_TOP: begin
        cmd_o.cap_top = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_LAST;
        state_d       = S_DN_LAST;
      end
      S_DN_LAST: begin
        cmd_o.load_last = 1'b1;
        cmd_o.pos_sel   = PS_ZERO;
        if (stat_i.occ_zero) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_SERVED;
          state_d      = S_IDLE;
        end else begin
          state_d = S_DN_CHK;
        end
      end
      S_DN_CHK: begin
        if (!stat_i.l_in) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_src = WS_ITEM;
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_SERVED;
          state_d      = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LEFT;
          state_d      = S_DN_L;
        end
      end
      S_DN_L: begin
        if (stat_i.r_in) begin
          cmd_o.take_left = 1'b1;
          cmd_o.rd_en     = 1'b1;
          cmd_o.rd_sel    = RD_RIGHT;
          state_d         = S_DN_R;
        end else if (stat_i.l_win) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_src  = WS_RDATA;
          cmd_o.pos_sel = PS_LEFT;
          state_d       = S_DN_CHK;
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_src = WS_ITEM;
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_SERVED;
          state_d      = S_IDLE;
        end
      end
      S_DN_R: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.r_win) begin
          cmd_o.wr_src  = WS_RDATA;
          cmd_o.pos_sel = PS_RIGHT;
          state_d       = S_DN_CHK;
        end else if (stat_i.best_child) begin
          cmd_o.wr_src  = WS_BEST;
          cmd_o.pos_sel = PS_BEST;
          state_d       = S_DN_CHK;
        end else begin
          cmd_o.wr_src = WS_BEST;
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_SERVED;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/spq_dp.sv @@
// Datapath with the heap memory, occupancy, arrival stamp and result registers.
module spq_dp
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [15:0] severity_i,
  input  logic [15:0] entry_id_i,
  output stat_t       stat_o,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [15:0] served_id_o,
  output logic [15:0] served_severity_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned OW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = AW + 2;

  entry_t mem [CAPACITY];

  entry_t          rdata_q;
  entry_t          item_q;
  entry_t          best_q;
  entry_t          top_q;
  entry_t          wdata;
  logic [AW-1:0]   pos_q;
  logic [AW-1:0]   best_idx_q;
  logic            best_child_q;
  logic [OW-1:0]   occ_q;
  logic [31:0]     stamp_q;
  logic            valid_q;
  logic [1:0]      status_q;
  logic [15:0]     sid_q;
  logic [15:0]     ssev_q;
  logic [AW-1:0]   parent;
  logic [CW-1:0]   left_w;
  logic [CW-1:0]   right_w;
  logic [AW-1:0]   raddr;

  assign parent  = AW'((pos_q - AW'(1)) >> 1);
  assign left_w  = CW'({pos_q, 1'b1});
  assign right_w = left_w + CW'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_ROOT:   raddr = '0;
      RD_PARENT: raddr = parent;
      RD_LAST:   raddr = AW'(occ_q);
      RD_LEFT:   raddr = AW'(left_w);
      RD_RIGHT:  raddr = AW'(right_w);
      default:   raddr = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_src)
      WS_ITEM:  wdata = item_q;
      WS_RDATA: wdata = rdata_q;
      WS_BEST:  wdata = best_q;
      default:  wdata = item_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[pos_q] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_ins) begin
      item_q <= '{sev: severity_i, id: entry_id_i, stamp: stamp_q};
    end else if (cmd_i.load_last) begin
      item_q <= rdata_q;
    end
    if (cmd_i.cap_top) begin
      top_q <= rdata_q;
    end
    if (cmd_i.take_left) begin
      if (goes_first(rdata_q, item_q)) begin
        best_q       <= rdata_q;
        best_idx_q   <= AW'(left_w);
        best_child_q <= 1'b1;
      end else begin
        best_q       <= item_q;
        best_idx_q   <= pos_q;
        best_child_q <= 1'b0;
      end
    end
    case (cmd_i.pos_sel)
      PS_HOLD:   pos_q <= pos_q;
      PS_OCC:    pos_q <= AW'(occ_q);
      PS_ZERO:   pos_q <= '0;
      PS_PARENT: pos_q <= parent;
      PS_LEFT:   pos_q <= AW'(left_w);
      PS_RIGHT:  pos_q <= AW'(right_w);
      PS_BEST:   pos_q <= best_idx_q;
      default:   pos_q <= pos_q;
    endcase
    if (cmd_i.finish) begin
      status_q <= cmd_i.status;
      if (cmd_i.status == ST_SERVED) begin
        sid_q  <= top_q.id;
        ssev_q <= top_q.sev;
      end else begin
        sid_q  <= '0;
        ssev_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      stamp_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_ins) begin
        occ_q   <= occ_q + OW'(1);
        stamp_q <= stamp_q + 32'd1;
      end else if (cmd_i.occ_dec) begin
        occ_q <= occ_q - OW'(1);
      end
      valid_q <= cmd_i.finish;
    end
  end

  always_comb begin
    stat_o.occ_zero   = (occ_q == '0);
    stat_o.occ_full   = (occ_q == OW'(CAPACITY));
    stat_o.pos_zero   = (pos_q == '0);
    stat_o.l_in       = (left_w < CW'(occ_q));
    stat_o.r_in       = (right_w < CW'(occ_q));
    stat_o.up_win     = goes_first(item_q, rdata_q);
    stat_o.l_win      = goes_first(rdata_q, item_q);
    stat_o.r_win      = goes_first(rdata_q, best_q);
    stat_o.best_child = best_child_q;
  end

  assign valid_o           = valid_q;
  assign status_o          = status_q;
  assign served_id_o       = sid_q;
  assign served_severity_o = ssev_q;

endmodule

@@ rtl/stable_priority_queue_top.sv @@
// Top level of the stable priority queue: controller and heap datapath.
//
//   channel   ports                                        handshake
//   request   mode_i, severity_i, entry_id_i               start high while busy low
//   result    status_o, served_id_o, served_severity_o     valid_o high for one cycle
//
// An insert places the entry at the first free slot and moves it up, reading the parent
// and moving the parent down while the entry goes first; a serve reads the root, takes the
// last entry to the root position and moves it down, reading the left and right children and
// writing up the child that goes first. A full-queue insert or an empty-queue serve finishes
// in its accepting cycle. Each step makes at most one memory read.
// The strobe follows the finishing cycle; reset empties the queue; the receiver cannot stall.
module stable_priority_queue_top
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [15:0] severity_i,
  input  logic [15:0] entry_id_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [15:0] served_id_o,
  output logic [15:0] served_severity_o
);

  cmd_t  cmd;
  stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (mode_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  spq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .severity_i        (severity_i),
    .entry_id_i        (entry_id_i),
    .stat_o            (stat),
    .valid_o           (valid_o),
    .status_o          (status_o),
    .served_id_o       (served_id_o),
    .served_severity_o (served_severity_o)
  );

endmodule
